@@ src/sha_pkg.sv @@
// Shared types, constants and round functions for the SHA-256 stream hasher.
// Depends on nothing; imported by the controller, the datapath and the top level.
package sha_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned NUM_WORDS = 8;
    localparam int unsigned WIN_W     = 512;
    localparam int unsigned ROUND_W   = 6;
    localparam int unsigned FILL_W    = 6;
    localparam int unsigned COUNT_W   = 64;
    localparam int unsigned IDX_W     = 3;

    localparam logic [BYTE_W-1:0] PAD_MARK_BYTE = 8'h80;
    localparam logic [FILL_W-1:0] LEN_START     = 6'd56;

    localparam logic [WORD_W-1:0] INIT_HASH [NUM_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [WORD_W-1:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD_MARK,
        S_PAD_ZERO,
        S_PAD_LEN,
        S_ROUND,
        S_UPDATE,
        S_HANDOFF
    } ctrl_state_t;

    typedef enum logic [1:0] {
        BYTE_DATA,
        BYTE_MARK,
        BYTE_ZERO,
        BYTE_LEN
    } byte_sel_t;

    typedef struct packed {
        logic      shift_en;
        byte_sel_t byte_sel;
        logic      count_en;
        logic      round_en;
        logic      update_en;
        logic      handoff;
    } ctrl_cmd_t;

    typedef struct packed {
        logic fill_full;
        logic fill_at_len;
        logic round_last;
        logic out_busy;
    } dp_stat_t;

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
                                               input int unsigned n);
        rotr = (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

@@ src/sha_ctrl.sv @@
// Controller state machine of the SHA-256 stream hasher: input handshake,
// padding sequence, compression rounds and digest hand-off. Uses sha_pkg.
module sha_ctrl
    import sha_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  logic      s_tuser,
    input  logic      s_tlast,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    ctrl_state_t state_reg, state_next;
    logic        end_reg, end_next;
    logic        pad_reg, pad_next;
    logic        final_reg, final_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            end_reg   <= 1'b0;
            pad_reg   <= 1'b0;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            end_reg   <= end_next;
            pad_reg   <= pad_next;
            final_reg <= final_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        end_next   = end_reg;
        pad_next   = pad_reg;
        final_next = final_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    end_next = s_tlast;
                    if (s_tuser && stat.fill_full)
                        state_next = S_ROUND;
                    else if (s_tlast)
                        state_next = S_PAD_MARK;
                end
            end
            S_PAD_MARK:
            begin
                pad_next   = 1'b1;
                state_next = stat.fill_full ? S_ROUND : S_PAD_ZERO;
            end
            S_PAD_ZERO:
            begin
                if (stat.fill_at_len)
                    state_next = S_PAD_LEN;
                else if (stat.fill_full)
                    state_next = S_ROUND;
            end
            S_PAD_LEN:
            begin
                if (stat.fill_full)
                begin
                    final_next = 1'b1;
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                if (stat.round_last)
                    state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                priority if (final_reg)
                    state_next = S_HANDOFF;
                else if (pad_reg)
                    state_next = S_PAD_ZERO;
                else if (end_reg)
                    state_next = S_PAD_MARK;
                else
                    state_next = S_IDLE;
            end
            S_HANDOFF:
            begin
                if (!stat.out_busy)
                begin
                    end_next   = 1'b0;
                    pad_next   = 1'b0;
                    final_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready      = 1'b0;
        cmd           = '0;
        cmd.byte_sel  = BYTE_DATA;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid && s_tuser)
                begin
                    cmd.shift_en = 1'b1;
                    cmd.count_en = 1'b1;
                end
            end
            S_PAD_MARK:
            begin
                cmd.shift_en = 1'b1;
                cmd.byte_sel = BYTE_MARK;
            end
            S_PAD_ZERO:
            begin
                cmd.shift_en = !stat.fill_at_len;
                cmd.byte_sel = BYTE_ZERO;
            end
            S_PAD_LEN:
            begin
                cmd.shift_en = 1'b1;
                cmd.byte_sel = BYTE_LEN;
            end
            S_ROUND:
            begin
                cmd.round_en = 1'b1;
            end
            S_UPDATE:
            begin
                cmd.update_en = 1'b1;
            end
            S_HANDOFF:
            begin
                cmd.handoff = !stat.out_busy;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    a_round_to_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND && stat.round_last) |=> state_reg == S_UPDATE)
        else $error("Round sequence did not end in the chaining update.");

    a_length_block_final: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PAD_LEN && stat.fill_full) |=> (final_reg && state_reg == S_ROUND))
        else $error("Length block was not marked as the final block.");

    a_final_after_pad: assert property (@(posedge clk) disable iff (!rst_n)
        final_reg |-> (pad_reg && end_reg))
        else $error("Final block flagged outside the padding sequence.");

endmodule

@@ src/sha_dp.sv @@
// Datapath of the SHA-256 stream hasher: message window and schedule, round
// variables, chaining words, counters and the digest output buffer. Uses sha_pkg.
module sha_dp
    import sha_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_cmd_t             cmd,
    output dp_stat_t              stat,
    input  logic [BYTE_W-1:0]     data_byte,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [WORD_W-1:0]     m_tdata,
    output logic [IDX_W-1:0]      m_tuser,
    output logic                  m_tlast
);

    logic [WIN_W-1:0]             win_reg, win_next;
    logic [WORD_W-1:0]            vars_reg [NUM_WORDS];
    logic [WORD_W-1:0]            vars_next [NUM_WORDS];
    logic [WORD_W-1:0]            chain_reg [NUM_WORDS];
    logic [COUNT_W-1:0]           count_reg;
    logic [FILL_W-1:0]            fill_reg;
    logic [ROUND_W-1:0]           round_reg;
    logic [NUM_WORDS*WORD_W-1:0]  out_words_reg;
    logic [IDX_W-1:0]             out_idx_reg;
    logic                         out_valid_reg;

    logic [COUNT_W-1:0]           bit_len;
    logic [COUNT_W-1:0]           len_shifted;
    logic [BYTE_W-1:0]            byte_in;
    logic [WORD_W-1:0]            w_cur;
    logic [WORD_W-1:0]            w_new;
    logic [WORD_W-1:0]            t1;
    logic [WORD_W-1:0]            t2;
    logic [NUM_WORDS*WORD_W-1:0]  chain_flat;
    logic                         out_take;

    assign bit_len     = {count_reg[COUNT_W-4:0], 3'b000};
    assign len_shifted = bit_len >> {~fill_reg[2:0], 3'b000};

    always_comb
    begin
        unique case (cmd.byte_sel)
            BYTE_DATA: byte_in = data_byte;
            BYTE_MARK: byte_in = PAD_MARK_BYTE;
            BYTE_ZERO: byte_in = '0;
            BYTE_LEN:  byte_in = len_shifted[BYTE_W-1:0];
            default:   byte_in = '0;
        endcase
    end

    // The window holds sixteen schedule words, oldest in the top bits.
    assign w_cur = win_reg[WIN_W-1 -: WORD_W];
    assign w_new = small_sigma1(win_reg[WIN_W-1-14*WORD_W -: WORD_W])
                 + win_reg[WIN_W-1-9*WORD_W -: WORD_W]
                 + small_sigma0(win_reg[WIN_W-1-WORD_W -: WORD_W])
                 + w_cur;

    assign t1 = vars_reg[7] + big_sigma1(vars_reg[4])
              + ((vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]))
              + ROUND_K[round_reg] + w_cur;
    assign t2 = big_sigma0(vars_reg[0])
              + ((vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
                 ^ (vars_reg[1] & vars_reg[2]));

    always_comb
    begin
        win_next = win_reg;
        if (cmd.shift_en)
            win_next = {win_reg[WIN_W-BYTE_W-1:0], byte_in};
        else if (cmd.round_en)
            win_next = {win_reg[WIN_W-WORD_W-1:0], w_new};
    end

    always_comb
    begin
        if (cmd.round_en)
        begin
            vars_next[0] = t1 + t2;
            vars_next[1] = vars_reg[0];
            vars_next[2] = vars_reg[1];
            vars_next[3] = vars_reg[2];
            vars_next[4] = vars_reg[3] + t1;
            vars_next[5] = vars_reg[4];
            vars_next[6] = vars_reg[5];
            vars_next[7] = vars_reg[6];
        end
        else
        begin
            vars_next = chain_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_WORDS; i++)
            chain_flat[(NUM_WORDS-1-i)*WORD_W +: WORD_W] = chain_reg[i];
    end

    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        vars_reg <= vars_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= INIT_HASH;
            count_reg <= '0;
            fill_reg  <= '0;
            round_reg <= '0;
        end
        else
        begin
            if (cmd.handoff)
                chain_reg <= INIT_HASH;
            else if (cmd.update_en)
            begin
                for (int i = 0; i < NUM_WORDS; i++)
                    chain_reg[i] <= chain_reg[i] + vars_reg[i];
            end
            if (cmd.handoff)
                count_reg <= '0;
            else if (cmd.count_en)
                count_reg <= count_reg + 1'b1;
            if (cmd.handoff)
                fill_reg <= '0;
            else if (cmd.shift_en)
                fill_reg <= fill_reg + 1'b1;
            round_reg <= cmd.round_en ? round_reg + 1'b1 : '0;
        end
    end

    assign out_take = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_idx_reg   <= '0;
        end
        else
        begin
            if (cmd.handoff)
            begin
                out_valid_reg <= 1'b1;
                out_idx_reg   <= '0;
            end
            else if (out_take)
            begin
                out_idx_reg <= out_idx_reg + 1'b1;
                if (out_idx_reg == IDX_W'(NUM_WORDS - 1))
                    out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.handoff)
            out_words_reg <= chain_flat;
        else if (out_take)
            out_words_reg <= {out_words_reg[NUM_WORDS*WORD_W-WORD_W-1:0], {WORD_W{1'b0}}};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_words_reg[NUM_WORDS*WORD_W-1 -: WORD_W];
    assign m_tuser  = out_idx_reg;
    assign m_tlast  = (out_idx_reg == IDX_W'(NUM_WORDS - 1));

    assign stat.fill_full   = (fill_reg == {FILL_W{1'b1}});
    assign stat.fill_at_len = (fill_reg == LEN_START);
    assign stat.round_last  = (round_reg == {ROUND_W{1'b1}});
    assign stat.out_busy    = out_valid_reg;

    a_handoff_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.handoff |-> !out_valid_reg)
        else $error("Digest handed off while the output buffer was busy.");

    a_drain_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && out_idx_reg == IDX_W'(NUM_WORDS - 1)) |=> !out_valid_reg)
        else $error("Output buffer still valid after its eighth beat.");

    a_no_shift_in_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.round_en |-> (!cmd.shift_en && !cmd.update_en))
        else $error("Window shifted or chain updated during a round.");

endmodule

@@ src/sha256_stream_hasher.sv @@
// Top level of the SHA-256 stream hasher: joins the controller and the datapath.
// Depends on sha_pkg, sha_ctrl and sha_dp.
//
// Channel   Direction  Beat contents
// s_*       in         tdata[7:0] message byte, tuser byte present, tlast end of message
// m_*       out        tdata[31:0] digest word, tuser[2:0] word index, tlast eighth word
//
// A message byte is taken while the controller is idle; each full 64-byte block then
// runs its rounds on the single shared round unit, followed by a chaining update.
// Closing a message shifts in up to 72 padding bytes, one per cycle while no compression
// runs, pauses without a shift where the length field starts, runs one or two
// compressions and hands the digest on once the output buffer is free.
// Reset loads the initial hash values at once; there is no clearing pass.
// A stalled output holds its word; a new digest waits until the buffer has drained.
module sha256_stream_hasher
    import sha_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] data_byte
    input  logic              s_tuser,   // [0] byte_present
    input  logic              s_tlast,   // end_of_message
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // [31:0] digest_word
    output logic [2:0]        m_tuser,   // [2:0] word_index
    output logic              m_tlast    // last_word
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    sha_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .stat     (stat),
        .cmd      (cmd)
    );

    sha_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .data_byte (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
